FILE: rtl/core/bmc_pkg.sv
`default_nettype none

package bmc_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_CHG_CUR_THR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DSG_CUR_THR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_START_CHG_SOC = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_START_DSG_SOC = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STOP_CHG_SOC = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STOP_DSG_SOC = 3'd5;

   localparam logic signed [15:0] CHG_CUR_THR_RST = 16'sd50;
   localparam logic signed [15:0] DSG_CUR_THR_RST = -16'sd50;
   localparam logic [6:0] START_CHG_SOC_RST = 7'd90;
   localparam logic [6:0] START_DSG_SOC_RST = 7'd20;
   localparam logic [6:0] STOP_CHG_SOC_RST = 7'd95;
   localparam logic [6:0] STOP_DSG_SOC_RST = 7'd5;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SET_SWITCH = 1'b1;

   typedef enum logic [1:0] {
      MODE_STANDBY = 2'd0,
      MODE_CHARGING = 2'd1,
      MODE_DISCHARGING = 2'd2,
      MODE_FAULT = 2'd3
   } mode_type;

   typedef struct packed {
      logic signed [15:0] chg_cur_thr;
      logic signed [15:0] dsg_cur_thr;
      logic [6:0] start_chg_soc;
      logic [6:0] start_dsg_soc;
      logic [6:0] stop_chg_soc;
      logic [6:0] stop_dsg_soc;
   } cfg_type;

   typedef struct packed {
      logic opcode;
      logic signed [15:0] current_ma;
      logic [6:0] charge_level;
      logic fault_active;
      logic new_charge_switch;
      logic new_discharge_switch;
   } req_type;

   typedef struct packed {
      mode_type mode;
      logic charge_switch;
      logic discharge_switch;
      logic charge_command;
      logic discharge_command;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/core/bmc_csr.sv
`default_nettype none

module bmc_csr (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [bmc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [bmc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bmc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready,
   output bmc_pkg::cfg_type cfg
);
   import bmc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic wr_en;
   logic [CSR_INDEX_W-1:0] index;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign index = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_CHG_CUR_THR: cfg_in.chg_cur_thr = csr_pwdata[15:0];
            REG_DSG_CUR_THR: cfg_in.dsg_cur_thr = csr_pwdata[15:0];
            REG_START_CHG_SOC: cfg_in.start_chg_soc = csr_pwdata[6:0];
            REG_START_DSG_SOC: cfg_in.start_dsg_soc = csr_pwdata[6:0];
            REG_STOP_CHG_SOC: cfg_in.stop_chg_soc = csr_pwdata[6:0];
            REG_STOP_DSG_SOC: cfg_in.stop_dsg_soc = csr_pwdata[6:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_CHG_CUR_THR: csr_prdata = CSR_DATA_W'(cfg_ff.chg_cur_thr);
         REG_DSG_CUR_THR: csr_prdata = CSR_DATA_W'(cfg_ff.dsg_cur_thr);
         REG_START_CHG_SOC: csr_prdata = {{(CSR_DATA_W-7){1'b0}}, cfg_ff.start_chg_soc};
         REG_START_DSG_SOC: csr_prdata = {{(CSR_DATA_W-7){1'b0}}, cfg_ff.start_dsg_soc};
         REG_STOP_CHG_SOC: csr_prdata = {{(CSR_DATA_W-7){1'b0}}, cfg_ff.stop_chg_soc};
         REG_STOP_DSG_SOC: csr_prdata = {{(CSR_DATA_W-7){1'b0}}, cfg_ff.stop_dsg_soc};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chg_cur_thr <= CHG_CUR_THR_RST;
         cfg_ff.dsg_cur_thr <= DSG_CUR_THR_RST;
         cfg_ff.start_chg_soc <= START_CHG_SOC_RST;
         cfg_ff.start_dsg_soc <= START_DSG_SOC_RST;
         cfg_ff.stop_chg_soc <= STOP_CHG_SOC_RST;
         cfg_ff.stop_dsg_soc <= STOP_DSG_SOC_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/bmc_fsm.sv
`default_nettype none

module bmc_fsm #(
   parameter int CONFIRM_TICKS = 3
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic step_en,
   input bmc_pkg::req_type req_data,
   input bmc_pkg::cfg_type cfg,
   output bmc_pkg::rsp_type rsp_data
);
   import bmc_pkg::*;

   localparam int CNT_W = $clog2(CONFIRM_TICKS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CONFIRM_TICKS);

   mode_type mode_ff, mode_in, mode_eff;
   logic chg_flag_ff, chg_flag_in;
   logic dsg_flag_ff, dsg_flag_in;
   logic [CNT_W-1:0] chg_req_cnt_ff, chg_req_cnt_in;
   logic [CNT_W-1:0] dsg_req_cnt_ff, dsg_req_cnt_in;
   logic [CNT_W-1:0] chg_done_cnt_ff, chg_done_cnt_in;
   logic [CNT_W-1:0] dsg_done_cnt_ff, dsg_done_cnt_in;
   logic chg_cmd, dsg_cmd;
   logic [CNT_W-1:0] chg_req_inc, dsg_req_inc, chg_done_inc, dsg_done_inc;

   assign mode_eff = req_data.fault_active ? MODE_FAULT : mode_ff;
   assign chg_req_inc = chg_req_cnt_ff + 1'b1;
   assign dsg_req_inc = dsg_req_cnt_ff + 1'b1;
   assign chg_done_inc = chg_done_cnt_ff + 1'b1;
   assign dsg_done_inc = dsg_done_cnt_ff + 1'b1;

   always_comb begin
      mode_in = mode_ff;
      chg_flag_in = chg_flag_ff;
      dsg_flag_in = dsg_flag_ff;
      chg_req_cnt_in = chg_req_cnt_ff;
      dsg_req_cnt_in = dsg_req_cnt_ff;
      chg_done_cnt_in = chg_done_cnt_ff;
      dsg_done_cnt_in = dsg_done_cnt_ff;
      chg_cmd = 1'b0;
      dsg_cmd = 1'b0;
      if (req_data.opcode == OP_SET_SWITCH) begin
         chg_flag_in = req_data.new_charge_switch;
         dsg_flag_in = req_data.new_discharge_switch;
      end else begin
         mode_in = mode_eff;
         unique case (mode_eff)
            MODE_STANDBY: begin
               if (req_data.current_ma > cfg.chg_cur_thr) begin
                  mode_in = MODE_CHARGING;
               end else if (req_data.current_ma < cfg.dsg_cur_thr) begin
                  mode_in = MODE_DISCHARGING;
               end
               if (!chg_flag_ff && (req_data.charge_level < cfg.start_chg_soc)) begin
                  if (chg_req_inc >= CNT_LAST) begin
                     chg_req_cnt_in = '0;
                     chg_flag_in = 1'b1;
                     chg_cmd = 1'b1;
                  end else begin
                     chg_req_cnt_in = chg_req_inc;
                  end
               end
               if (!dsg_flag_ff && (req_data.charge_level > cfg.start_dsg_soc)) begin
                  if (dsg_req_inc >= CNT_LAST) begin
                     dsg_req_cnt_in = '0;
                     dsg_flag_in = 1'b1;
                     dsg_cmd = 1'b1;
                  end else begin
                     dsg_req_cnt_in = dsg_req_inc;
                  end
               end
            end
            MODE_CHARGING: begin
               if (req_data.current_ma < cfg.chg_cur_thr) begin
                  mode_in = MODE_STANDBY;
               end else if (req_data.charge_level >= cfg.stop_chg_soc) begin
                  if (chg_done_inc >= CNT_LAST) begin
                     chg_done_cnt_in = '0;
                     mode_in = MODE_STANDBY;
                     chg_flag_in = 1'b0;
                     chg_cmd = 1'b1;
                  end else begin
                     chg_done_cnt_in = chg_done_inc;
                  end
               end
            end
            MODE_DISCHARGING: begin
               if (req_data.current_ma > cfg.dsg_cur_thr) begin
                  mode_in = MODE_STANDBY;
               end else if (req_data.charge_level <= cfg.stop_dsg_soc) begin
                  if (dsg_done_inc >= CNT_LAST) begin
                     dsg_done_cnt_in = '0;
                     mode_in = MODE_STANDBY;
                     dsg_flag_in = 1'b0;
                     dsg_cmd = 1'b1;
                  end else begin
                     dsg_done_cnt_in = dsg_done_inc;
                  end
               end
            end
            MODE_FAULT: begin
               if (!req_data.fault_active) begin
                  mode_in = MODE_STANDBY;
               end
            end
            default: mode_in = MODE_STANDBY;
         endcase
      end
   end

   assign rsp_data.mode = mode_in;
   assign rsp_data.charge_switch = chg_flag_in;
   assign rsp_data.discharge_switch = dsg_flag_in;
   assign rsp_data.charge_command = chg_cmd;
   assign rsp_data.discharge_command = dsg_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_STANDBY;
         chg_flag_ff <= 1'b1;
         dsg_flag_ff <= 1'b1;
         chg_req_cnt_ff <= '0;
         dsg_req_cnt_ff <= '0;
         chg_done_cnt_ff <= '0;
         dsg_done_cnt_ff <= '0;
      end else if (step_en) begin
         mode_ff <= mode_in;
         chg_flag_ff <= chg_flag_in;
         dsg_flag_ff <= dsg_flag_in;
         chg_req_cnt_ff <= chg_req_cnt_in;
         dsg_req_cnt_ff <= dsg_req_cnt_in;
         chg_done_cnt_ff <= chg_done_cnt_in;
         dsg_done_cnt_ff <= dsg_done_cnt_in;
      end
   end

   a_cnt_below_last: assert property (@(posedge clock) disable iff (reset)
      (chg_req_cnt_ff < CNT_LAST) && (dsg_req_cnt_ff < CNT_LAST) &&
      (chg_done_cnt_ff < CNT_LAST) && (dsg_done_cnt_ff < CNT_LAST))
      else $error("confirmation counter reached its limit without clearing");

   a_chg_cmd_dir: assert property (@(posedge clock) disable iff (reset)
      step_en && chg_cmd |-> chg_flag_in == (mode_eff == MODE_STANDBY))
      else $error("charge command does not match the charge switch direction");

   a_dsg_cmd_dir: assert property (@(posedge clock) disable iff (reset)
      step_en && dsg_cmd |-> dsg_flag_in == (mode_eff == MODE_STANDBY))
      else $error("discharge command does not match the discharge switch direction");

   a_set_keeps_mode: assert property (@(posedge clock) disable iff (reset)
      step_en && (req_data.opcode == OP_SET_SWITCH) |=> mode_ff == $past(mode_ff))
      else $error("direct switch write changed the mode");

   a_fault_forces_mode: assert property (@(posedge clock) disable iff (reset)
      step_en && (req_data.opcode == OP_TICK) && req_data.fault_active
      |=> mode_ff == MODE_FAULT)
      else $error("raised fault did not leave the block in fault mode");

endmodule

`default_nettype wire

FILE: rtl/core/battery_mode_controller.sv
// Battery pack mode controller.
// Requests arrive on the req_ channel (req_valid, req_stall, req_data) and each one
// produces exactly one response on the rsp_ channel (rsp_valid, rsp_stall, rsp_data).
// A request is taken at a rising edge with valid high and stall low, on both sides.
// Every request goes into an input register; when the response register is free,
// the mode logic evaluates it against the stored mode, switch flags and counters,
// updates that state and loads the response register, so each request passes the
// input and then the response register. While the receiver does not stall, one
// request per cycle is sustained; the mode and counter loop holds no extra register.
// When the receiver stalls, the response register holds; the input register still
// takes one more request, and req_stall rises only once both are full.
// The user must write thresholds through the csr_ port (pready always high) only
// while no request is in flight (not enforced); they read back sign or zero extended.
// Synchronous reset empties both registers, puts the block in standby with both
// switches enabled and all counters at zero, and restores the threshold defaults.

`default_nettype none

module battery_mode_controller #(
   parameter int CONFIRM_TICKS = 3
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input bmc_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output bmc_pkg::rsp_type rsp_data,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [bmc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [bmc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bmc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import bmc_pkg::*;

   cfg_type cfg;
   logic in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type step_rsp;
   logic out_free, step_en, req_take;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign step_en = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !step_en);
   assign out_valid_in = step_en || (out_valid_ff && rsp_stall);

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   bmc_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .cfg(cfg)
   );

   bmc_fsm #(
      .CONFIRM_TICKS(CONFIRM_TICKS)
   ) u_fsm (
      .clock(clock),
      .reset(reset),
      .step_en(step_en),
      .req_data(in_data_ff),
      .cfg(cfg),
      .rsp_data(step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (step_en) begin
         out_data_ff <= step_rsp;
      end
   end

endmodule

`default_nettype wire

FILE: bench/battery_mode_controller_test.sv
`timescale 1ns / 1ps

module battery_mode_controller_test;
   import bmc_pkg::*;

   localparam int CONFIRM_TICKS = 3;
   localparam int PHASES = 10;
   localparam int ITEMS_PER_PHASE = 188;
   localparam int SCRIPT_ROWS = 24;

   typedef struct {
      req_type stim;
      bit typed;
      rsp_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   logic signed [15:0] charge_thr;
   logic signed [15:0] discharge_thr;
   logic [6:0] start_charge_level;
   logic [6:0] start_discharge_level;
   logic [6:0] stop_charge_level;
   logic [6:0] stop_discharge_level;

   mode_type pack_mode;
   logic charge_on;
   logic discharge_on;
   logic [1:0] charge_resume_count;
   logic [1:0] discharge_resume_count;
   logic [1:0] charge_full_count;
   logic [1:0] discharge_empty_count;

   rsp_type expected_status[$];
   int requests_taken = 0;
   int statuses_checked = 0;
   int failures = 0;
   bit steady = 1'b0;

   always #5 clock = ~clock;

   battery_mode_controller #(
      .CONFIRM_TICKS(CONFIRM_TICKS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   function automatic void restore_defaults();
      charge_thr = CHG_CUR_THR_RST;
      discharge_thr = DSG_CUR_THR_RST;
      start_charge_level = START_CHG_SOC_RST;
      start_discharge_level = START_DSG_SOC_RST;
      stop_charge_level = STOP_CHG_SOC_RST;
      stop_discharge_level = STOP_DSG_SOC_RST;
      pack_mode = MODE_STANDBY;
      charge_on = 1'b1;
      discharge_on = 1'b1;
      charge_resume_count = '0;
      discharge_resume_count = '0;
      charge_full_count = '0;
      discharge_empty_count = '0;
   endfunction

   function automatic rsp_type predict_status(req_type r);
      rsp_type s;
      logic signed [15:0] cur;
      cur = r.current_ma;
      s.charge_command = 1'b0;
      s.discharge_command = 1'b0;
      if (r.opcode == OP_SET_SWITCH) begin
         charge_on = r.new_charge_switch;
         discharge_on = r.new_discharge_switch;
      end else begin
         if (r.fault_active) pack_mode = MODE_FAULT;
         case (pack_mode)
            MODE_STANDBY: begin
               if (cur > charge_thr) pack_mode = MODE_CHARGING;
               else if (cur < discharge_thr) pack_mode = MODE_DISCHARGING;
               if (!charge_on && r.charge_level < start_charge_level) begin
                  charge_resume_count = charge_resume_count + 2'd1;
                  if (charge_resume_count >= CONFIRM_TICKS) begin
                     charge_resume_count = '0;
                     charge_on = 1'b1;
                     s.charge_command = 1'b1;
                  end
               end
               if (!discharge_on && r.charge_level > start_discharge_level) begin
                  discharge_resume_count = discharge_resume_count + 2'd1;
                  if (discharge_resume_count >= CONFIRM_TICKS) begin
                     discharge_resume_count = '0;
                     discharge_on = 1'b1;
                     s.discharge_command = 1'b1;
                  end
               end
            end
            MODE_CHARGING: begin
               if (cur < charge_thr) begin
                  pack_mode = MODE_STANDBY;
               end else if (r.charge_level >= stop_charge_level) begin
                  charge_full_count = charge_full_count + 2'd1;
                  if (charge_full_count >= CONFIRM_TICKS) begin
                     charge_full_count = '0;
                     pack_mode = MODE_STANDBY;
                     charge_on = 1'b0;
                     s.charge_command = 1'b1;
                  end
               end
            end
            MODE_DISCHARGING: begin
               if (cur > discharge_thr) begin
                  pack_mode = MODE_STANDBY;
               end else if (r.charge_level <= stop_discharge_level) begin
                  discharge_empty_count = discharge_empty_count + 2'd1;
                  if (discharge_empty_count >= CONFIRM_TICKS) begin
                     discharge_empty_count = '0;
                     pack_mode = MODE_STANDBY;
                     discharge_on = 1'b0;
                     s.discharge_command = 1'b1;
                  end
               end
            end
            default: begin
               if (!r.fault_active) pack_mode = MODE_STANDBY;
            end
         endcase
      end
      s.mode = pack_mode;
      s.charge_switch = charge_on;
      s.discharge_switch = discharge_on;
      return s;
   endfunction

   task automatic note_mismatch(string field, logic [1:0] want, logic [1:0] got);
      failures++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
   endtask

   always @(posedge clock) begin : status_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_status.size() == 0) begin
            failures++;
            $display("%0t: no response expected, got %h", $time, rsp_data);
         end else begin
            want = expected_status.pop_front();
            if (rsp_data.mode !== want.mode) note_mismatch("mode", want.mode, rsp_data.mode);
            if (rsp_data.charge_switch !== want.charge_switch)
               note_mismatch("charge_switch", want.charge_switch, rsp_data.charge_switch);
            if (rsp_data.discharge_switch !== want.discharge_switch)
               note_mismatch("discharge_switch", want.discharge_switch,
                  rsp_data.discharge_switch);
            if (rsp_data.charge_command !== want.charge_command)
               note_mismatch("charge_command", want.charge_command, rsp_data.charge_command);
            if (rsp_data.discharge_command !== want.discharge_command)
               note_mismatch("discharge_command", want.discharge_command,
                  rsp_data.discharge_command);
            statuses_checked++;
         end
      end
   end

   initial begin : response_pacing
      int unsigned hold;
      forever begin
         hold = steady ? 0 : $urandom_range(0, 8);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   task automatic send_request(req_type r, bit typed, rsp_type typed_status);
      int unsigned gap;
      rsp_type predicted;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = predict_status(r);
      expected_status.push_back(typed ? typed_status : predicted);
      requests_taken++;
   endtask

   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (statuses_checked < requests_taken) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_transfer(logic [CSR_INDEX_W-1:0] index, logic write,
         logic [CSR_DATA_W-1:0] wdata, output logic [CSR_DATA_W-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, int value);
      logic [CSR_DATA_W-1:0] shown;
      logic [CSR_DATA_W-1:0] readback;
      shown = {25'd0, value[6:0]};
      case (index)
         REG_CHG_CUR_THR: begin
            charge_thr = value[15:0];
            shown = {{16{value[15]}}, value[15:0]};
         end
         REG_DSG_CUR_THR: begin
            discharge_thr = value[15:0];
            shown = {{16{value[15]}}, value[15:0]};
         end
         REG_START_CHG_SOC: start_charge_level = value[6:0];
         REG_START_DSG_SOC: start_discharge_level = value[6:0];
         REG_STOP_CHG_SOC: stop_charge_level = value[6:0];
         default: stop_discharge_level = value[6:0];
      endcase
      csr_transfer(index, 1'b1, shown, readback);
      csr_transfer(index, 1'b0, '0, readback);
      if (readback !== shown) begin
         failures++;
         $display("%0t: register %0d expected %h, got %h", $time, index, shown, readback);
      end
   endtask

   task automatic load_setting(int phase);
      int values[6];
      case (phase)
         1: values = '{32767, -32768, 0, 100, 100, 0};
         2: values = '{-32768, 32767, 100, 0, 0, 100};
         3: values = '{0, 0, 50, 50, 50, 50};
         PHASES - 1: values = '{50, -50, 90, 20, 95, 5};
         default: begin
            values[0] = int'($urandom_range(0, 400)) - 200;
            values[1] = int'($urandom_range(0, 400)) - 300;
            for (int i = 2; i < 6; i++) values[i] = $urandom_range(0, 100);
         end
      endcase
      write_register(REG_CHG_CUR_THR, values[0]);
      write_register(REG_DSG_CUR_THR, values[1]);
      write_register(REG_START_CHG_SOC, values[2]);
      write_register(REG_START_DSG_SOC, values[3]);
      write_register(REG_STOP_CHG_SOC, values[4]);
      write_register(REG_STOP_DSG_SOC, values[5]);
   endtask

   function automatic logic signed [15:0] clamp_current(int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic [6:0] clamp_level(int v);
      if (v > 127) return 7'd127;
      if (v < 0) return 7'd0;
      return v[6:0];
   endfunction

   function automatic script_row_type tick(int cur, int lvl, logic flt);
      script_row_type row;
      row.stim = '0;
      row.stim.opcode = OP_TICK;
      row.stim.current_ma = cur[15:0];
      row.stim.charge_level = lvl[6:0];
      row.stim.fault_active = flt;
      row.typed = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic script_row_type set_switches(logic chg, logic dsg);
      script_row_type row;
      row = tick(32767, 127, 1'b1);
      row.stim.opcode = OP_SET_SWITCH;
      row.stim.new_charge_switch = chg;
      row.stim.new_discharge_switch = dsg;
      return row;
   endfunction

   function automatic script_row_type with_status(script_row_type row, mode_type m,
         logic chg_on, logic dsg_on, logic chg_cmd, logic dsg_cmd);
      row.typed = 1'b1;
      row.want.mode = m;
      row.want.charge_switch = chg_on;
      row.want.discharge_switch = dsg_on;
      row.want.charge_command = chg_cmd;
      row.want.discharge_command = dsg_cmd;
      return row;
   endfunction

   // Walks a full charge to completion, a full discharge to completion, both
   // re-enable counters, fault entry and exit, a direct switch write, and the
   // current and level thresholds at and beside their reset values.
   function automatic script_row_type script_row(int i);
      script_row_type row;
      case (i)
         0: row = with_status(tick(0, 50, 0), MODE_STANDBY, 1, 1, 0, 0);
         1: row = with_status(tick(32767, 100, 0), MODE_CHARGING, 1, 1, 0, 0);
         2, 3: row = tick(32767, 100, 0);
         4: row = with_status(tick(32767, 100, 0), MODE_STANDBY, 0, 1, 1, 0);
         5: row = tick(0, 0, 0);
         6, 7, 8: row = tick(-32768, 0, 0);
         9: row = with_status(tick(-32768, 0, 0), MODE_STANDBY, 0, 0, 0, 1);
         10: row = with_status(tick(0, 50, 0), MODE_STANDBY, 1, 0, 1, 0);
         11: row = with_status(tick(0, 127, 1), MODE_FAULT, 1, 0, 0, 0);
         12: row = tick(0, 127, 1);
         13: row = with_status(set_switches(0, 0), MODE_FAULT, 0, 0, 0, 0);
         14: row = with_status(tick(0, 127, 0), MODE_STANDBY, 0, 0, 0, 0);
         15: row = tick(100, 127, 0);
         16: row = tick(50, 127, 0);
         17: row = tick(49, 0, 0);
         18: row = tick(50, 21, 0);
         19: row = tick(-50, 89, 0);
         20: row = tick(-51, 90, 0);
         21: row = tick(-50, 5, 0);
         22: row = tick(-49, 5, 0);
         default: row = with_status(set_switches(1, 1), MODE_STANDBY, 1, 1, 0, 0);
      endcase
      return row;
   endfunction

   // A run repeats one operating point with small jitter so that the
   // three-tick counters get a chance to complete.
   task automatic send_run();
      int base_current;
      int base_level;
      int length;
      int pick;
      bit faulty;
      req_type r;
      pick = $urandom_range(0, 9);
      if (pick < 4) base_current = int'(charge_thr) + int'($urandom_range(0, 6)) - 3;
      else if (pick < 7) base_current = int'(discharge_thr) + int'($urandom_range(0, 6)) - 3;
      else if (pick == 7) base_current = int'($urandom_range(0, 40)) - 20;
      else base_current = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 5))
         0: base_level = int'(start_charge_level) + int'($urandom_range(0, 4)) - 2;
         1: base_level = int'(start_discharge_level) + int'($urandom_range(0, 4)) - 2;
         2: base_level = int'(stop_charge_level) + int'($urandom_range(0, 4)) - 2;
         3: base_level = int'(stop_discharge_level) + int'($urandom_range(0, 4)) - 2;
         default: base_level = $urandom_range(0, 127);
      endcase
      length = $urandom_range(1, 6);
      faulty = ($urandom_range(0, 19) == 0);
      steady = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < length; k++) begin
         r.opcode = ($urandom_range(0, 15) == 0) ? OP_SET_SWITCH : OP_TICK;
         r.current_ma = clamp_current(base_current + int'($urandom_range(0, 2)) - 1);
         r.charge_level = clamp_level(base_level + int'($urandom_range(0, 2)) - 1);
         r.fault_active = faulty && ($urandom_range(0, 3) != 0);
         r.new_charge_switch = 1'($urandom_range(0, 1));
         r.new_discharge_switch = 1'($urandom_range(0, 1));
         send_request(r, 1'b0, '0);
      end
   endtask

   initial begin : stimulus
      script_row_type row;
      int target;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      reset <= 1'b1;
      restore_defaults();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         row = script_row(i);
         send_request(row.stim, row.typed, row.want);
      end
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_quiet();
         if (phase > 0) load_setting(phase);
         target = requests_taken + ITEMS_PER_PHASE;
         while (requests_taken < target) send_run();
      end
      steady = 1'b0;
      wait_for_quiet();
      repeat (8) @(posedge clock);
      if (expected_status.size() != 0) begin
         failures++;
         $display("%0t: %0d responses expected, got none", $time, expected_status.size());
      end
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
